FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check of a property, sampled on clk and ignored while rst_n is low.
`define BTOFC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("btofc check failed");

// Concurrent check of a condition that must hold at every sampled edge.
`define BTOFC_CHECK(label, cond) \
  `BTOFC_ASSERT(label, (cond))

`endif

FILE: design/btofc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package btofc_pkg;

  localparam int NUM_COUNTERS_DEF = 176;
  localparam int NUM_COEFFS_DEF   = 7;
  localparam int NUM_TERMS        = 7;
  localparam int ADC_W            = 12;
  localparam int ADC_DEPTH        = 4096;
  localparam int ROM_W            = 17;
  localparam int COEFF_W          = 32;
  localparam int TIME_W           = 24;
  localparam int Z_W              = 16;
  localparam int SUM_W            = 56;
  localparam int ACC_W            = 58;
  localparam int IN_DATA_W        = 96;
  localparam int OUT_DATA_W       = 32;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_CORRECT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ADC_ZERO = 2'd1,
    ST_RANGE    = 2'd2
  } status_t;

  typedef logic [ROM_W-1:0] rom_t [ADC_DEPTH];

  // Builds the reciprocal tables at elaboration. With recip low the entry is
  // round(2^16 / sqrt(a)), else round(2^16 / a); ties round upward.
  function automatic rom_t build_rom(input logic recip);
    rom_t        r;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] d;
    logic [63:0] lhs;
    r[0] = '0;
    for (int a = 1; a < ADC_DEPTH; a++) begin
      lo = 64'd1;
      hi = 64'd65536;
      while (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        d   = 2 * mid - 64'd1;
        if (recip) begin
          lhs = d * 64'(a);
          if (lhs <= (64'd1 << 17)) lo = mid;
          else hi = mid - 64'd1;
        end else begin
          lhs = d * d * 64'(a);
          if (lhs <= (64'd1 << 34)) lo = mid;
          else hi = mid - 64'd1;
        end
      end
      r[a] = lo[ROM_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/barrel_tof_time_correction_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Barrel time-of-flight hit time correction. A load transaction (tuser low) writes
// one of seven signed coefficients, scaled by 2^-24, for one end of one counter.
// A correct transaction (tuser high) returns tdc - common_offset - (p0 + p1/sqrt(adc)
// + p2*z/sqrt(adc) + p3/adc + p4*z + p5*z^2 + p6*z^3), rounded to the 2^-10 ns time
// LSB and saturated to 24 bits, with a negative flag and a status code (ok, adc
// zero, counter or slot out of range). The block takes one transaction every clock
// cycle unless back-pressure on the result stream has filled the pipeline; its six
// register stages are set by the registered read of the coefficient memories and
// the reciprocal ROMs followed by the split wide multiplies of the cubic and z/sqrt
// terms. Coefficients live in seven memories of 2*NUM_COUNTERS words, one per
// term, so that a hit reads all of them in the same cycle. The memories are not
// cleared: a counter must be loaded before its hits are corrected. Loads and hits
// are applied in acceptance order, so a hit right after a load sees the new value.
module barrel_tof_time_correction_unit
  import btofc_pkg::*;
#(
  parameter int NUM_COUNTERS = NUM_COUNTERS_DEF,
  parameter int NUM_COEFFS   = NUM_COEFFS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input stream. tdata, low bit up: counter[7:0], side, coeff_index[2:0],
  // coeff_value[31:0], adc[11:0], tdc[23:0], z_pos[15:0].
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // tuser: operation (0 load, 1 correct).
  input  wire logic                  in_tuser,
  // Result stream. tdata, low bit up: corrected_time[23:0], negative, zero pad.
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // tuser: status[1:0].
  output logic [1:0]                 out_tuser,
  // Common time offset register.
  input  wire logic                  cfg_wr_en,
  input  wire logic [TIME_W-1:0]     cfg_wr_data
);

  localparam int ROWS = 2 * NUM_COUNTERS;
  localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;

  localparam rom_t RSQ_ROM  = build_rom(1'b0);
  localparam rom_t RINV_ROM = build_rom(1'b1);

  // Round p / 2^sh to nearest, ties away from zero.
  function automatic logic signed [SUM_W-1:0] rnd(input logic signed [79:0] p,
                                                 input int unsigned sh);
    logic signed [80:0] t;
    logic signed [80:0] q;
    t = 81'(p) + (81'sd1 <<< (sh - 1)) - $signed({80'd0, p[79]});
    q = t >>> sh;
    return q[SUM_W-1:0];
  endfunction

  // Input field unpacking.
  logic                       op;
  logic [7:0]                 counter;
  logic                       side;
  logic [2:0]                 cidx;
  logic [COEFF_W-1:0]         cval;
  logic [ADC_W-1:0]           adc;
  logic signed [TIME_W-1:0]   tdc;
  logic signed [Z_W-1:0]      zpos;

  assign op      = in_tuser;
  assign counter = in_tdata[7:0];
  assign side    = in_tdata[8];
  assign cidx    = in_tdata[11:9];
  assign cval    = in_tdata[43:12];
  assign adc     = in_tdata[55:44];
  assign tdc     = $signed(in_tdata[79:56]);
  assign zpos    = $signed(in_tdata[95:80]);

  // Common offset register.
  logic signed [TIME_W-1:0] off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r <= '0;
    end else if (cfg_wr_en) begin
      off_r <= $signed(cfg_wr_data);
    end
  end

  // Stage advance: a stage loads when it is empty or its successor moves on.
  logic g1, g2, g3, g4, g5, g6;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;

  assign g6 = !v6_r || out_tready;
  assign g5 = !v5_r || g6;
  assign g4 = !v4_r || g5;
  assign g3 = !v3_r || g4;
  assign g2 = !v2_r || g3;
  assign g1 = !v1_r || g2;
  assign in_tready = g1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (g1) v1_r <= in_tvalid;
      if (g2) v2_r <= v1_r;
      if (g3) v3_r <= v2_r;
      if (g4) v4_r <= v3_r;
      if (g5) v5_r <= v4_r;
      if (g6) v6_r <= v5_r;
    end
  end

  // Entry checks. A counter out of range wins over a zero ADC reading.
  logic    accept;
  logic    cnt_ok;
  logic    idx_ok;
  status_t st0;
  logic    kill0;
  logic [8:0]    row;
  logic [AW-1:0] addr;

  assign accept = in_tvalid && g1;
  assign cnt_ok = ({1'b0, counter} < 9'(NUM_COUNTERS));
  assign idx_ok = ({1'b0, cidx} < 4'(NUM_COEFFS));
  assign row    = {counter, side};
  assign addr   = row[AW-1:0];

  always_comb begin
    if (op == OP_LOAD) begin
      st0 = (cnt_ok && idx_ok) ? ST_OK : ST_RANGE;
    end else if (!cnt_ok) begin
      st0 = ST_RANGE;
    end else if (adc == '0) begin
      st0 = ST_ADC_ZERO;
    end else begin
      st0 = ST_OK;
    end
    kill0 = (op == OP_LOAD) || (st0 != ST_OK);
  end

  // Stage 1: coefficient memories and reciprocal ROMs, registered reads.
  logic [COEFF_W-1:0]       p_s1_r [NUM_TERMS];
  logic [ROM_W-1:0]         rs_s1_r;
  logic [ROM_W-1:0]         ri_s1_r;
  logic signed [TIME_W-1:0] tdc_s1_r;
  logic signed [Z_W-1:0]    z_s1_r;
  status_t                  st_s1_r;
  logic                     kill_s1_r;

  for (genvar k = 0; k < NUM_TERMS; k++) begin : g_coef
    logic [COEFF_W-1:0] mem [ROWS];
    logic               we;

    assign we = accept && (op == OP_LOAD) && cnt_ok && idx_ok && (cidx == 3'(k));

    always_ff @(posedge clk) begin
      if (we) begin
        mem[addr] <= cval;
      end
      if (g1) begin
        p_s1_r[k] <= mem[addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (g1) begin
      rs_s1_r   <= RSQ_ROM[adc];
      ri_s1_r   <= RINV_ROM[adc];
      tdc_s1_r  <= tdc;
      z_s1_r    <= zpos;
      st_s1_r   <= st0;
      kill_s1_r <= kill0;
    end
  end

  // Stage 2: first products.
  logic signed [49:0]        m1_s2_r;
  logic signed [49:0]        m3_s2_r;
  logic signed [47:0]        m4_s2_r;
  logic signed [31:0]        zz_s2_r;
  logic signed [33:0]        zr_s2_r;
  logic signed [COEFF_W-1:0] p0_s2_r, p2_s2_r, p5_s2_r, p6_s2_r;
  logic signed [Z_W-1:0]     z_s2_r;
  logic signed [TIME_W-1:0]  tdc_s2_r;
  status_t                   st_s2_r;
  logic                      kill_s2_r;

  always_ff @(posedge clk) begin
    if (g2) begin
      m1_s2_r   <= $signed(p_s1_r[1]) * $signed({1'b0, rs_s1_r});
      m3_s2_r   <= $signed(p_s1_r[3]) * $signed({1'b0, ri_s1_r});
      m4_s2_r   <= $signed(p_s1_r[4]) * z_s1_r;
      zz_s2_r   <= z_s1_r * z_s1_r;
      zr_s2_r   <= z_s1_r * $signed({1'b0, rs_s1_r});
      p0_s2_r   <= $signed(p_s1_r[0]);
      p2_s2_r   <= $signed(p_s1_r[2]);
      p5_s2_r   <= $signed(p_s1_r[5]);
      p6_s2_r   <= $signed(p_s1_r[6]);
      z_s2_r    <= z_s1_r;
      tdc_s2_r  <= tdc_s1_r;
      st_s2_r   <= st_s1_r;
      kill_s2_r <= kill_s1_r;
    end
  end

  // Stage 3: round the short terms into a partial sum; split z/sqrt product;
  // quadratic product and cube of z.
  logic signed [SUM_W-1:0]   a_s3_r;
  logic signed [49:0]        m2lo_s3_r;
  logic signed [48:0]        m2hi_s3_r;
  logic signed [63:0]        m5_s3_r;
  logic signed [46:0]        z3_s3_r;
  logic signed [COEFF_W-1:0] p6_s3_r;
  logic signed [TIME_W-1:0]  tdc_s3_r;
  status_t                   st_s3_r;
  logic                      kill_s3_r;

  always_ff @(posedge clk) begin
    if (g3) begin
      a_s3_r    <= SUM_W'(p0_s2_r) + rnd(80'(m1_s2_r), 16) + rnd(80'(m3_s2_r), 16)
                   + rnd(80'(m4_s2_r), 8);
      m2lo_s3_r <= p2_s2_r * $signed({1'b0, zr_s2_r[16:0]});
      m2hi_s3_r <= p2_s2_r * $signed(zr_s2_r[33:17]);
      m5_s3_r   <= p5_s2_r * zz_s2_r;
      z3_s3_r   <= zz_s2_r * z_s2_r;
      p6_s3_r   <= p6_s2_r;
      tdc_s3_r  <= tdc_s2_r;
      st_s3_r   <= st_s2_r;
      kill_s3_r <= kill_s2_r;
    end
  end

  // Stage 4: finish the z/sqrt and quadratic terms; split cubic product.
  logic signed [63:0]        m2;
  logic signed [SUM_W-1:0]   a_s4_r;
  logic signed [56:0]        m6lo_s4_r;
  logic signed [54:0]        m6hi_s4_r;
  logic signed [TIME_W-1:0]  tdc_s4_r;
  status_t                   st_s4_r;
  logic                      kill_s4_r;

  assign m2 = (64'(m2hi_s3_r) <<< 17) + 64'(m2lo_s3_r);

  always_ff @(posedge clk) begin
    if (g4) begin
      a_s4_r    <= a_s3_r + rnd(80'(m2), 24) + rnd(80'(m5_s3_r), 16);
      m6lo_s4_r <= p6_s3_r * $signed({1'b0, z3_s3_r[23:0]});
      m6hi_s4_r <= p6_s3_r * $signed(z3_s3_r[46:24]);
      tdc_s4_r  <= tdc_s3_r;
      st_s4_r   <= st_s3_r;
      kill_s4_r <= kill_s3_r;
    end
  end

  // Stage 5: cubic term, full sum and the accumulator at 2^-24 ns.
  logic signed [77:0]        m6;
  logic signed [SUM_W-1:0]   sum5;
  logic signed [TIME_W:0]    diff5;
  logic signed [ACC_W-1:0]   acc_s5_r;
  status_t                   st_s5_r;
  logic                      kill_s5_r;

  assign m6    = (78'(m6hi_s4_r) <<< 24) + 78'(m6lo_s4_r);
  assign sum5  = a_s4_r + rnd(80'(m6), 24);
  assign diff5 = (TIME_W + 1)'(tdc_s4_r) - (TIME_W + 1)'(off_r);

  always_ff @(posedge clk) begin
    if (g5) begin
      acc_s5_r  <= (ACC_W'(diff5) <<< 14) - ACC_W'(sum5);
      st_s5_r   <= st_s4_r;
      kill_s5_r <= kill_s4_r;
    end
  end

  // Stage 6: round to the time LSB, saturate, output register.
  logic signed [ACC_W:0]      accr;
  logic signed [ACC_W-14:0]   q6;
  logic signed [TIME_W-1:0]   ct6;
  logic signed [TIME_W-1:0]   time_r;
  logic                       neg_r;
  status_t                    st_r;

  always_comb begin
    accr = (ACC_W + 1)'(acc_s5_r) + 59'sd8192 - $signed({58'd0, acc_s5_r[ACC_W-1]});
    q6   = (ACC_W - 13)'(accr >>> 14);
    if (q6 > 45'sd8388607) begin
      ct6 = 24'sd8388607;
    end else if (q6 < -45'sd8388608) begin
      ct6 = -24'sd8388608;
    end else begin
      ct6 = q6[TIME_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (g6) begin
      time_r <= kill_s5_r ? '0 : ct6;
      neg_r  <= kill_s5_r ? 1'b0 : ct6[TIME_W-1];
      st_r   <= st_s5_r;
    end
  end

  assign out_tvalid = v6_r;
  assign out_tdata  = {(OUT_DATA_W - TIME_W - 1)'(0), neg_r, time_r};
  assign out_tuser  = st_r;

endmodule

`default_nettype wire

FILE: design/btofc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module btofc_checker
  import btofc_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic [1:0]            out_tuser
);

  // A stalled result keeps its value until it is taken.
  `BTOFC_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // Results with a non-OK status (rejected loads and hits) carry a zero time and a clear flag.
  `BTOFC_ASSERT(a_err_zero, out_tvalid && out_tuser != ST_OK |-> out_tdata == '0)

  // The negative flag follows the sign of the reported time.
  `BTOFC_CHECK(a_neg_sign, !out_tvalid || out_tdata[24] == out_tdata[23])

  // Padding above the flag stays zero.
  `BTOFC_CHECK(a_pad_zero, !out_tvalid || out_tdata[OUT_DATA_W-1:25] == '0)

endmodule

bind barrel_tof_time_correction_unit btofc_checker u_btofc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

FILE: dv/tof_correction_checker.sv
`timescale 1ns / 1ps

// Watches both streams and the offset register port, predicts every result and
// compares it with what the block returns.
module tof_correction_checker
  import btofc_pkg::*;
#(
  parameter int NUM_COUNTERS = NUM_COUNTERS_DEF,
  parameter int NUM_COEFFS   = NUM_COEFFS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic [1:0]            out_tuser,
  input  logic                  cfg_wr_en,
  input  logic [TIME_W-1:0]     cfg_wr_data,
  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    logic signed [15:0] z_pos;
    logic signed [23:0] tdc;
    logic [11:0]        adc;
    logic signed [31:0] coeff_value;
    logic [2:0]         coeff_index;
    logic               side;
    logic [7:0]         counter;
  } tof_item_t;

  typedef struct packed {
    logic signed [23:0] ctime;
    logic               negative;
    status_t            status;
  } tof_result_t;

  localparam logic signed [127:0] T_HI = 128'sd8388607;
  localparam logic signed [127:0] T_LO = -128'sd8388608;

  logic signed [31:0]  coeff_mem [NUM_COUNTERS*2*NUM_COEFFS];
  logic signed [23:0]  time_offset;
  tof_result_t         corrected_q [$];
  int                  errors;

  // Rounded (a*b) / 2^sh, ties away from zero.
  function automatic logic signed [127:0] scaled_product(input logic signed [127:0] a,
                                                         input logic signed [127:0] b,
                                                         input int sh);
    logic signed [127:0] prod;
    logic signed [127:0] m;
    prod = a * b;
    m = (prod < 0) ? -prod : prod;
    m = (m + (128'sd1 << (sh - 1))) >>> sh;
    return (prod < 0) ? -m : m;
  endfunction

  // Nearest 2^16/sqrt(a): the largest r with (2r-1)^2 * a <= 2^34.
  function automatic logic [63:0] inv_sqrt_rom(input logic [11:0] a);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    lo = 64'd1;
    hi = 64'd65536;
    while (lo < hi) begin
      mid = (lo + hi + 64'd1) >> 1;
      if ((2 * mid - 1) * (2 * mid - 1) * 64'(a) <= (64'd1 << 34)) lo = mid;
      else hi = mid - 64'd1;
    end
    return lo;
  endfunction

  function automatic tof_result_t correct_hit(input logic op, input tof_item_t it);
    tof_result_t         r;
    int                  base;
    logic signed [127:0] p [7];
    logic signed [127:0] z;
    logic signed [127:0] rs;
    logic signed [127:0] ri;
    logic signed [127:0] sum;
    logic signed [127:0] acc;
    logic signed [127:0] m;
    r = '{ctime: '0, negative: 1'b0, status: ST_OK};
    base = (int'(it.counter) * 2 + int'(it.side)) * NUM_COEFFS;
    if (op == OP_LOAD) begin
      if (it.counter >= NUM_COUNTERS || it.coeff_index >= NUM_COEFFS) r.status = ST_RANGE;
      else coeff_mem[base + int'(it.coeff_index)] = it.coeff_value;
    end else if (it.counter >= NUM_COUNTERS) begin
      r.status = ST_RANGE;
    end else if (it.adc == '0) begin
      r.status = ST_ADC_ZERO;
    end else begin
      for (int k = 0; k < 7; k++) p[k] = coeff_mem[base + k];
      z  = it.z_pos;
      rs = 128'(inv_sqrt_rom(it.adc));
      ri = 128'((64'd65536 + 64'(it.adc) / 2) / 64'(it.adc));
      sum = p[0] + scaled_product(p[1], rs, 16) + scaled_product(p[2], z * rs, 24)
          + scaled_product(p[3], ri, 16) + scaled_product(p[4], z, 8)
          + scaled_product(p[5], z * z, 16) + scaled_product(p[6], z * z * z, 24);
      acc = (128'(it.tdc) - 128'(time_offset)) * 16384 - sum;
      m = (((acc < 0) ? -acc : acc) + 8192) >>> 14;
      if (acc < 0) m = -m;
      if (m > T_HI) m = T_HI;
      if (m < T_LO) m = T_LO;
      r.ctime = m[23:0];
      r.negative = (m < 0);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    tof_result_t exp_r;
    tof_result_t got_r;
    if (!rst_n) begin
      time_offset = '0;
      corrected_q.delete();
      errors = 0;
    end else begin
      if (cfg_wr_en) time_offset = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        corrected_q.insert(corrected_q.size(), correct_hit(in_tuser, in_tdata));
      end
      if (out_tvalid && out_tready) begin
        got_r = '{ctime: out_tdata[23:0], negative: out_tdata[24], status: status_t'(out_tuser)};
        if (corrected_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: time %0d neg %0d status %0d",
                   $time, got_r.ctime, got_r.negative, got_r.status);
        end else begin
          exp_r = corrected_q.pop_front();
          if (got_r.ctime !== exp_r.ctime) begin
            errors++;
            $display("%0t: corrected_time expected %0d actual %0d",
                     $time, exp_r.ctime, got_r.ctime);
          end
          if (got_r.negative !== exp_r.negative) begin
            errors++;
            $display("%0t: negative expected %0d actual %0d",
                     $time, exp_r.negative, got_r.negative);
          end
          if (got_r.status !== exp_r.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got_r.status);
          end
        end
      end
    end
    fail_count <= errors;
    pending <= corrected_q.size();
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the barrel time-of-flight correction unit. The checker
// beside the block predicts and compares; this module only drives transactions,
// applies back-pressure and decides the outcome.
module testbench;
  import btofc_pkg::*;

  localparam int NCNT = NUM_COUNTERS_DEF;
  localparam int NPAIR = NCNT * 2;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = OP_LOAD;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  cfg_wr_en = 1'b0;
  logic [TIME_W-1:0]     cfg_wr_data = '0;
  int                    fail_count;
  int                    pending;

  // Which of the seven slots of each counter end have been loaded. A hit that passes
  // the entry checks is only aimed at an end whose slots are all written, so no stale memory is used.
  logic [6:0]            slots_loaded [NPAIR];
  int                    ready_pairs [$];
  int                    sent_count = 0;
  int                    hit_count = 0;
  bit                    steady = 1'b0;

  always #6 clk = ~clk;

  barrel_tof_time_correction_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  tof_correction_checker scoreboard (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .fail_count(fail_count), .pending(pending)
  );

  // Offers one transaction and holds it until the block accepts it. Random idle
  // cycles go in front of it unless the sender is in its steady stretch. Valid is
  // only lowered inside the idle loop, so back-to-back transactions keep it high.
  task automatic send_item(input logic op, input logic [7:0] counter, input logic side,
                           input logic [2:0] slot, input logic [31:0] coeff,
                           input logic [11:0] adc, input logic [23:0] tdc,
                           input logic [15:0] z);
    while (!steady && $urandom_range(99) < 23) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {z, tdc, adc, coeff, slot, side, counter};
    do @(posedge clk); while (!in_tready);
    sent_count++;
    if (op == OP_CORRECT) hit_count++;
  endtask

  // Records a load so that hits can later target a fully written counter end.
  task automatic note_load(input int counter, input int side, input int slot);
    int pair;
    pair = counter * 2 + side;
    if (counter < NCNT && slot < 7) begin
      if (slots_loaded[pair] != 7'h7f) begin
        slots_loaded[pair][slot] = 1'b1;
        if (slots_loaded[pair] == 7'h7f) ready_pairs.insert(ready_pairs.size(), pair);
      end
    end
  endtask

  function automatic logic [31:0] pick_coeff();
    case ($urandom_range(4))
      0: return $urandom;
      1: return 32'($signed($urandom) >>> $urandom_range(6, 28));
      2: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      3: return 32'($signed($urandom) >>> $urandom_range(20, 31));
      default: return '0;
    endcase
  endfunction

  function automatic logic [11:0] pick_adc();
    case ($urandom_range(3))
      0: return 12'($urandom_range(1, 16));
      1: return 12'hfff;
      default: return 12'($urandom_range(1, 4095));
    endcase
  endfunction

  function automatic logic [15:0] pick_z();
    case ($urandom_range(3))
      0: return $urandom_range(1) ? 16'h7fff : 16'h8000;
      1: return 16'($signed($urandom) >>> $urandom_range(18, 30));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic load_pair(input int counter, input int side);
    logic [31:0] v;
    for (int k = 0; k < 7; k++) begin
      v = pick_coeff();
      send_item(OP_LOAD, 8'(counter), 1'(side), 3'(k), v, 12'($urandom), 24'($urandom),
                16'($urandom));
      note_load(counter, side, k);
    end
  endtask

  task automatic hit(input int counter, input int side, input logic [11:0] adc,
                     input logic [23:0] tdc, input logic [15:0] z);
    send_item(OP_CORRECT, 8'(counter), 1'(side), 3'($urandom), $urandom, adc, tdc, z);
  endtask

  // Offset writes happen only with the stream drained and the pipeline empty.
  task automatic write_offset(input logic [23:0] value);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(input int n_items);
    int target;
    int r;
    int c;
    int s;
    int pair;
    target = sent_count + n_items;
    while (sent_count < target) begin
      r = $urandom_range(99);
      if (r < 12 || ready_pairs.size() == 0) begin
        load_pair($urandom_range(NCNT - 1), $urandom_range(1));
      end else if (r < 20) begin
        // Single loads, some with a counter or slot beyond the table.
        c = $urandom_range(255);
        s = $urandom_range(1);
        send_item(OP_LOAD, 8'(c), 1'(s), 3'($urandom_range(7)), pick_coeff(),
                  12'($urandom), 24'($urandom), 16'($urandom));
        note_load(c, s, in_tdata[11:9]);
      end else if (r < 25) begin
        hit($urandom_range(NCNT, 255), $urandom_range(1), pick_adc(), 24'($urandom), pick_z());
      end else if (r < 30) begin
        hit($urandom_range(NCNT - 1), $urandom_range(1), 12'd0, 24'($urandom), pick_z());
      end else begin
        pair = ready_pairs[$urandom_range(ready_pairs.size() - 1)];
        hit(pair / 2, pair % 2, pick_adc(), 24'($urandom), pick_z());
      end
    end
  endtask

  // Receiver: random stalls, one long hold-off so the block fills up and stops
  // accepting, and a long stretch with out_tready held high.
  initial begin
    int cycle;
    cycle = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      cycle++;
      if (cycle >= 300 && cycle < 400) out_tready <= 1'b0;
      else if (cycle >= 1000 && cycle < 1400) out_tready <= 1'b1;
      else out_tready <= ($urandom_range(99) >= 23);
    end
  end

  initial begin
    for (int i = 0; i < NPAIR; i++) slots_loaded[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under a zero offset.
    write_offset(24'd0);
    for (int k = 0; k < 7; k++) begin
      send_item(OP_LOAD, 8'd175, 1'b1, 3'(k), 32'h7fff_ffff, 12'hfff, 24'hffffff, 16'hffff);
      note_load(175, 1, k);
    end
    for (int k = 0; k < 7; k++) begin
      send_item(OP_LOAD, 8'd0, 1'b0, 3'(k), 32'h8000_0000, 12'h000, 24'h000000, 16'h0000);
      note_load(0, 0, k);
    end
    // End (1,0) holds p0 of one LSB and zeros elsewhere, so a hit at tdc zero
    // lands just below zero and rounds to zero with the negative flag clear.
    for (int k = 0; k < 7; k++) begin
      send_item(OP_LOAD, 8'd1, 1'b0, 3'(k), (k == 0) ? 32'd1 : 32'd0, 12'd5, 24'd0, 16'd0);
      note_load(1, 0, k);
    end
    send_item(OP_LOAD, 8'd176, 1'b0, 3'd0, 32'd5, 12'd0, 24'd0, 16'd0);
    send_item(OP_LOAD, 8'd3, 1'b1, 3'd7, 32'd5, 12'd0, 24'd0, 16'd0);
    hit(1, 0, 12'd100, 24'd0, 16'd0);
    hit(175, 1, 12'd1, 24'h800000, 16'h8000);
    hit(0, 0, 12'hfff, 24'h7fffff, 16'h7fff);
    hit(0, 0, 12'd1, 24'h000000, 16'h8000);
    hit(255, 1, 12'd7, 24'd9, 16'd1);
    hit(175, 1, 12'd0, 24'd9, 16'd1);

    // Random phases across offset settings, extremes included. The second one
    // runs with the sender never idling.
    write_offset(24'h7fffff);
    random_phase(100);
    write_offset(24'h800000);
    steady = 1'b1;
    random_phase(100);
    steady = 1'b0;
    write_offset(24'($urandom));
    random_phase(100);
    write_offset(24'($signed($urandom) >>> 12));
    random_phase(100);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d transactions (%0d hits) over five offset settings,", sent_count,
             hit_count);
    $display("with %0d counter ends fully loaded and random stalls on both streams.",
             ready_pairs.size());
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/btofc_pkg.sv
design/barrel_tof_time_correction_unit.sv
design/btofc_checker.sv
dv/tof_correction_checker.sv
dv/testbench.sv
